// ----- rtl/svf_pkg.sv -----
// Package: constants, types and datapath functions of the scanline video filter.
package svf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int PIXEL_BITS   = 32;

   localparam int WORD_BITS    = 32;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
   localparam int W_BITS       = COL_BITS + 1;
   localparam int H_BITS       = ROW_BITS + 1;
   localparam int BANK_DEPTH   = MAX_WIDTH / 2;
   localparam int BANK_BITS    = COL_BITS - 1;
   localparam int DIM_BITS     = 11;
   localparam int SHIFT_BITS   = 5;
   localparam int MODE_BITS    = 3;

   localparam int OUT_ROW_BITS = 10;
   localparam int OUT_COL_BITS = 10;
   localparam int RSP_FIELDS   = OUT_ROW_BITS + OUT_COL_BITS + WORD_BITS;
   localparam int RSP_BITS     = ((RSP_FIELDS + 7) / 8) * 8;

   localparam int NSLOT        = 4;
   localparam int SLOT_BITS    = $clog2(NSLOT);
   localparam int CNT_BITS     = $clog2(NSLOT + 1);

   localparam int ADDR_BITS    = 5;
   localparam int CSR_BITS     = 32;

   localparam logic [WORD_BITS-1:0] PIX_MASK =
      WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_PASS = 3'd0,
      MODE_MIX  = 3'd1,
      MODE_HALF = 3'd2,
      MODE_COPY = 3'd3,
      MODE_ZERO = 3'd4
   } scan_mode_type;

   typedef enum logic [2:0] {
      REG_SCAN_MODE    = 3'd0,
      REG_BLUR_ON      = 3'd1,
      REG_LINE_WIDTH   = 3'd2,
      REG_FRAME_HEIGHT = 3'd3,
      REG_RED_SHIFT    = 3'd4,
      REG_GREEN_SHIFT  = 3'd5,
      REG_BLUE_SHIFT   = 3'd6,
      REG_ALPHA_BITS   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  scan_mode;
      logic                  blur_on;
      logic [DIM_BITS-1:0]   line_width;
      logic [DIM_BITS-1:0]   frame_height;
      logic [SHIFT_BITS-1:0] red_shift;
      logic [SHIFT_BITS-1:0] green_shift;
      logic [SHIFT_BITS-1:0] blue_shift;
      logic [WORD_BITS-1:0]  alpha_bits;
   } cfg_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]  row;
      logic [COL_BITS-1:0]  col;
      logic [WORD_BITS-1:0] pixel;
   } slot_type;

   typedef struct packed {
      logic [NSLOT-1:0]         valid;
      slot_type [NSLOT-1:0]     slot;
   } group_type;

   typedef struct packed {
      logic                 valid;
      logic                 stranded;
      logic                 odd_row;
      logic [ROW_BITS-1:0]  row;
      logic [COL_BITS-1:0]  col;
      logic [WORD_BITS-1:0] pixel;
      logic                 held_emit;
      logic [ROW_BITS-1:0]  held_row;
      logic [COL_BITS-1:0]  held_col;
      logic [WORD_BITS-1:0] held_value;
      logic                 cur_emit;
      logic                 hold;
   } stage_type;

   function automatic int clamp_dim(int v, int maxv);
      int r;
      r = v;
      if (v < 2) r = 2;
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   function automatic logic [WORD_BITS-1:0] chan_mask(cfg_type cfg);
      logic [WORD_BITS-1:0] lows;
      lows = (WORD_BITS'(1) << cfg.red_shift) | (WORD_BITS'(1) << cfg.green_shift) |
             (WORD_BITS'(1) << cfg.blue_shift);
      return ~lows & ~cfg.alpha_bits & PIX_MASK;
   endfunction

   function automatic logic [WORD_BITS-1:0] avg2(logic [WORD_BITS-1:0] a,
                                                  logic [WORD_BITS-1:0] b,
                                                  logic [WORD_BITS-1:0] m);
      logic [WORD_BITS:0] s;
      s = {1'b0, a & m} + {1'b0, b & m};
      return s[WORD_BITS:1] & PIX_MASK;
   endfunction

endpackage

// ----- rtl/svf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module svf_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 512,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/svf_pipe.sv -----
// Filter pipeline: raster counters, blur hold, line memory access and result build.
module svf_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  svf_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [svf_pkg::WORD_BITS-1:0] req_tdata,
   input  logic                          load_ok,
   output logic                          load,
   output svf_pkg::group_type            group
);

   logic [svf_pkg::WORD_BITS-1:0] mask;
   logic [svf_pkg::W_BITS-1:0]    w;
   logic [svf_pkg::H_BITS-1:0]    h;

   logic [svf_pkg::ROW_BITS-1:0]  row_ff, row_in;
   logic [svf_pkg::COL_BITS-1:0]  col_ff, col_in;
   logic                          held_valid_ff, held_valid_in;
   logic [svf_pkg::ROW_BITS-1:0]  held_row_ff, held_row_in;
   logic [svf_pkg::COL_BITS-1:0]  held_col_ff, held_col_in;
   logic [svf_pkg::WORD_BITS-1:0] held_pixel_ff, held_pixel_in;
   logic [svf_pkg::WORD_BITS-1:0] held_above_ff, held_above_in;
   svf_pkg::stage_type            s1_ff, s1_in;

   logic                          stranded, s1_free, advance, accept, even, hold_now;
   logic [svf_pkg::WORD_BITS-1:0] pix;

   logic [svf_pkg::WORD_BITS-1:0] even_rdata, odd_rdata, above_cur;
   logic                          even_we, odd_we;
   logic [svf_pkg::BANK_BITS-1:0] even_wa, odd_wa, rd_addr;
   logic [svf_pkg::WORD_BITS-1:0] even_wd, odd_wd;

   logic                          is_mix, held_mix_ok, cur_mix_ok, near_bottom, odd_put;
   logic [svf_pkg::WORD_BITS-1:0] odd_pix;

   assign mask = svf_pkg::chan_mask(cfg);
   assign w = svf_pkg::W_BITS'(svf_pkg::clamp_dim(int'(cfg.line_width), svf_pkg::MAX_WIDTH));
   assign h = svf_pkg::H_BITS'(svf_pkg::clamp_dim(int'(cfg.frame_height),
                                                  svf_pkg::MAX_HEIGHT));

   assign stranded   = held_valid_ff && (held_row_ff != row_ff);
   assign advance    = s1_ff.valid && load_ok;
   assign s1_free    = !s1_ff.valid || load_ok;
   assign req_tready = s1_free && !stranded;
   assign accept     = req_tvalid && req_tready;
   assign pix        = req_tdata & svf_pkg::PIX_MASK;
   assign even       = !row_ff[0];
   assign hold_now   = even && cfg.blur_on && col_ff[0] &&
                       (({1'b0, col_ff} + svf_pkg::W_BITS'(1)) < w);

   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      held_valid_in = held_valid_ff;
      held_row_in   = held_row_ff;
      held_col_in   = held_col_ff;
      held_pixel_in = held_pixel_ff;
      s1_in         = s1_ff;
      if (advance) begin
         s1_in.valid = 1'b0;
      end
      if (accept) begin
         s1_in.valid      = 1'b1;
         s1_in.stranded   = 1'b0;
         s1_in.odd_row    = row_ff[0];
         s1_in.row        = row_ff;
         s1_in.col        = col_ff;
         s1_in.pixel      = pix;
         s1_in.held_emit  = even && held_valid_ff;
         s1_in.held_row   = row_ff;
         s1_in.held_col   = held_col_ff;
         s1_in.held_value = svf_pkg::avg2(held_pixel_ff, pix, mask);
         s1_in.cur_emit   = even && !hold_now;
         s1_in.hold       = hold_now;
         if (even && held_valid_ff) begin
            held_valid_in = 1'b0;
         end
         if (hold_now) begin
            held_valid_in = 1'b1;
            held_row_in   = row_ff;
            held_col_in   = col_ff;
            held_pixel_in = pix;
         end
         if (({1'b0, col_ff} + svf_pkg::W_BITS'(1)) >= w) begin
            col_in = '0;
            row_in = (({1'b0, row_ff} + svf_pkg::H_BITS'(1)) >= h) ? '0 :
                     row_ff + svf_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + svf_pkg::COL_BITS'(1);
         end
      end else if (stranded && s1_free) begin
         // row moved on under a held blur pixel: flush it unblurred
         s1_in.valid      = 1'b1;
         s1_in.stranded   = 1'b1;
         s1_in.odd_row    = 1'b0;
         s1_in.row        = row_ff;
         s1_in.col        = col_ff;
         s1_in.pixel      = held_pixel_ff;
         s1_in.held_emit  = 1'b1;
         s1_in.held_row   = held_row_ff;
         s1_in.held_col   = held_col_ff;
         s1_in.held_value = held_pixel_ff;
         s1_in.cur_emit   = 1'b0;
         s1_in.hold       = 1'b0;
         held_valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         held_valid_ff <= 1'b0;
         s1_ff         <= '0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         held_valid_ff <= held_valid_in;
         s1_ff         <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      held_row_ff   <= held_row_in;
      held_col_ff   <= held_col_in;
      held_pixel_ff <= held_pixel_in;
      held_above_ff <= held_above_in;
   end

   // line memory split by column parity: a blur pair writes both banks at once
   assign rd_addr = col_ff[svf_pkg::COL_BITS-1:1];

   svf_ram #(.WIDTH(svf_pkg::WORD_BITS), .DEPTH(svf_pkg::BANK_DEPTH)) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wa),
      .wr_data (even_wd),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (even_rdata)
   );

   svf_ram #(.WIDTH(svf_pkg::WORD_BITS), .DEPTH(svf_pkg::BANK_DEPTH)) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wa),
      .wr_data (odd_wd),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (odd_rdata)
   );

   assign above_cur     = s1_ff.col[0] ? odd_rdata : even_rdata;
   assign held_above_in = (advance && s1_ff.hold) ? above_cur : held_above_ff;

   assign even_we = advance && s1_ff.cur_emit && !s1_ff.col[0];
   assign even_wa = s1_ff.col[svf_pkg::COL_BITS-1:1];
   assign even_wd = s1_ff.pixel;
   assign odd_we  = advance && (s1_ff.held_emit || (s1_ff.cur_emit && s1_ff.col[0]));
   assign odd_wa  = s1_ff.held_emit ? s1_ff.held_col[svf_pkg::COL_BITS-1:1] :
                                      s1_ff.col[svf_pkg::COL_BITS-1:1];
   assign odd_wd  = s1_ff.held_emit ? s1_ff.held_value : s1_ff.pixel;

   assign is_mix      = (cfg.scan_mode == svf_pkg::MODE_MIX);
   assign held_mix_ok = is_mix && (s1_ff.held_row != '0) &&
                        (({1'b0, s1_ff.held_row} + svf_pkg::H_BITS'(1)) < h);
   assign cur_mix_ok  = is_mix && (s1_ff.row != '0) &&
                        (({1'b0, s1_ff.row} + svf_pkg::H_BITS'(1)) < h);
   assign near_bottom = ({1'b0, s1_ff.row} + svf_pkg::H_BITS'(2)) >= h;

   always_comb begin
      odd_put = 1'b1;
      odd_pix = '0;
      case (cfg.scan_mode)
         svf_pkg::MODE_MIX: begin
            odd_put = near_bottom;
         end
         svf_pkg::MODE_HALF: begin
            odd_pix = near_bottom ? '0 : ((above_cur & mask) >> 1) & svf_pkg::PIX_MASK;
         end
         svf_pkg::MODE_COPY: begin
            odd_pix = above_cur;
         end
         svf_pkg::MODE_ZERO: begin
            odd_pix = '0;
         end
         default: begin
            odd_pix = s1_ff.pixel;
         end
      endcase
   end

   always_comb begin
      group.valid[0]       = s1_ff.held_emit;
      group.slot[0].row    = s1_ff.held_row;
      group.slot[0].col    = s1_ff.held_col;
      group.slot[0].pixel  = s1_ff.held_value;
      group.valid[1]       = s1_ff.held_emit && held_mix_ok;
      group.slot[1].row    = s1_ff.held_row - svf_pkg::ROW_BITS'(1);
      group.slot[1].col    = s1_ff.held_col;
      group.slot[1].pixel  = svf_pkg::avg2(held_above_ff, s1_ff.held_value, mask);
      group.valid[2]       = s1_ff.odd_row ? odd_put : s1_ff.cur_emit;
      group.slot[2].row    = s1_ff.row;
      group.slot[2].col    = s1_ff.col;
      group.slot[2].pixel  = s1_ff.odd_row ? odd_pix : s1_ff.pixel;
      group.valid[3]       = !s1_ff.odd_row && s1_ff.cur_emit && cur_mix_ok;
      group.slot[3].row    = s1_ff.row - svf_pkg::ROW_BITS'(1);
      group.slot[3].col    = s1_ff.col;
      group.slot[3].pixel  = svf_pkg::avg2(above_cur, s1_ff.pixel, mask);
   end

   assign load = advance;

   a_held_col_odd: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.held_emit |-> s1_ff.held_col[0])
      else $error("held blur pixel on an even column");

   a_pair_adjacent: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.held_emit && !s1_ff.stranded |->
      s1_ff.col == s1_ff.held_col + svf_pkg::COL_BITS'(1))
      else $error("blur pair completed by a non-adjacent pixel");

   a_hold_sets: assert property (@(posedge clock) disable iff (reset)
      accept && hold_now |=> held_valid_ff)
      else $error("blur hold lost");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !load_ok |=> s1_ff.valid)
      else $error("stalled stage dropped its word");

endmodule

// ----- rtl/svf_outbuf.sv -----
// Result buffer: holds the writes of one pixel and hands them out one word per cycle while rsp_tready is high.
module svf_outbuf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  svf_pkg::group_type           group,
   output logic                         load_ok,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [svf_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                         rsp_tlast
);

   svf_pkg::slot_type             ent_ff [svf_pkg::NSLOT];
   svf_pkg::slot_type             ent_in [svf_pkg::NSLOT];
   logic [svf_pkg::CNT_BITS-1:0]  count_ff, count_in, k;
   logic [svf_pkg::SLOT_BITS-1:0] head_ff, head_in;
   logic                          pop;
   svf_pkg::slot_type             cur;

   assign pop     = (count_ff != '0) && rsp_tready;
   assign load_ok = (count_ff == '0) || ((count_ff == svf_pkg::CNT_BITS'(1)) && rsp_tready);

   always_comb begin
      ent_in   = ent_ff;
      count_in = count_ff;
      head_in  = head_ff;
      k        = '0;
      if (load) begin
         for (int i = 0; i < svf_pkg::NSLOT; i++) begin
            if (group.valid[i]) begin
               ent_in[k[svf_pkg::SLOT_BITS-1:0]] = group.slot[i];
               k = k + svf_pkg::CNT_BITS'(1);
            end
         end
         count_in = k;
         head_in  = '0;
      end else if (pop) begin
         count_in = count_ff - svf_pkg::CNT_BITS'(1);
         head_in  = head_ff + svf_pkg::SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign cur        = ent_ff[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = (count_ff == svf_pkg::CNT_BITS'(1));
   assign rsp_tdata  = {(svf_pkg::RSP_BITS - svf_pkg::RSP_FIELDS)'(0), cur.pixel,
                        svf_pkg::OUT_COL_BITS'(cur.col), svf_pkg::OUT_ROW_BITS'(cur.row)};

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ok)
      else $error("result group loaded over pending words");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= svf_pkg::CNT_BITS'(svf_pkg::NSLOT))
      else $error("result count out of range");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      pop && !load |=> count_ff == $past(count_ff) - svf_pkg::CNT_BITS'(1))
      else $error("result count not stepped on pop");

endmodule

// ----- rtl/scanline_video_filter_top.sv -----
// Top level of the scanline video filter: register file, pipeline and result buffer.
//
// Pixels enter in raster order, one word per cycle while req_tready is high, and
// each produces zero to four pixel writes tagged with row and column. The result
// port delivers one write per cycle while rsp_tready is high; a pixel moves on to
// the result buffer once the writes of the one before are out or the last leaves,
// so a pixel with several writes holds back the input. A pixel is registered in
// the pipeline stage, then in the result buffer. The row above lives in two
// 512 x 32 memory banks split by column parity, read when a pixel is taken and
// written back as it moves on to the result buffer, so both pixels of a blur pair
// are stored in the same cycle. The line memory needs no clearing after reset.
// Registers are to be written only while the block is idle; this is not enforced.
module scanline_video_filter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [svf_pkg::WORD_BITS-1:0] req_tdata,   // pixel_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [svf_pkg::RSP_BITS-1:0]  rsp_tdata,   // out_row, out_col, out_pixel
   output logic                          rsp_tlast,   // last_of_run
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [svf_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [svf_pkg::CSR_BITS-1:0]  csr_pwdata,
   output logic [svf_pkg::CSR_BITS-1:0]  csr_prdata,
   output logic                          csr_pready
);

   svf_pkg::cfg_type       cfg_ff, cfg_in;
   svf_pkg::reg_index_type idx;
   svf_pkg::group_type     group;
   logic                   wr, load, load_ok;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = svf_pkg::reg_index_type'(csr_paddr[svf_pkg::ADDR_BITS-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            svf_pkg::REG_SCAN_MODE:    cfg_in.scan_mode    = csr_pwdata[svf_pkg::MODE_BITS-1:0];
            svf_pkg::REG_BLUR_ON:      cfg_in.blur_on      = csr_pwdata[0];
            svf_pkg::REG_LINE_WIDTH:   cfg_in.line_width   = csr_pwdata[svf_pkg::DIM_BITS-1:0];
            svf_pkg::REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[svf_pkg::DIM_BITS-1:0];
            svf_pkg::REG_RED_SHIFT:    cfg_in.red_shift    = csr_pwdata[svf_pkg::SHIFT_BITS-1:0];
            svf_pkg::REG_GREEN_SHIFT:  cfg_in.green_shift  = csr_pwdata[svf_pkg::SHIFT_BITS-1:0];
            svf_pkg::REG_BLUE_SHIFT:   cfg_in.blue_shift   = csr_pwdata[svf_pkg::SHIFT_BITS-1:0];
            svf_pkg::REG_ALPHA_BITS:   cfg_in.alpha_bits   = csr_pwdata[svf_pkg::WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_mode    <= svf_pkg::MODE_PASS;
         cfg_ff.blur_on      <= 1'b0;
         cfg_ff.line_width   <= svf_pkg::DIM_BITS'(640);
         cfg_ff.frame_height <= svf_pkg::DIM_BITS'(480);
         cfg_ff.red_shift    <= svf_pkg::SHIFT_BITS'(16);
         cfg_ff.green_shift  <= svf_pkg::SHIFT_BITS'(8);
         cfg_ff.blue_shift   <= svf_pkg::SHIFT_BITS'(0);
         cfg_ff.alpha_bits   <= 32'hFF00_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         svf_pkg::REG_SCAN_MODE:    csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.scan_mode);
         svf_pkg::REG_BLUR_ON:      csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.blur_on);
         svf_pkg::REG_LINE_WIDTH:   csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.line_width);
         svf_pkg::REG_FRAME_HEIGHT: csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.frame_height);
         svf_pkg::REG_RED_SHIFT:    csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.red_shift);
         svf_pkg::REG_GREEN_SHIFT:  csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.green_shift);
         svf_pkg::REG_BLUE_SHIFT:   csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.blue_shift);
         svf_pkg::REG_ALPHA_BITS:   csr_prdata = svf_pkg::CSR_BITS'(cfg_ff.alpha_bits);
         default:                   csr_prdata = '0;
      endcase
   end

   svf_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .load_ok    (load_ok),
      .load       (load),
      .group      (group)
   );

   svf_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .group      (group),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- verif/scanline_video_filter_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the scanline video filter top level.
module scanline_video_filter_top_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 460;
   localparam int CALM_ITEMS    = 80;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int WIDE_RUN      = 41;

   typedef struct packed {
      logic [svf_pkg::OUT_ROW_BITS-1:0] row;
      logic [svf_pkg::OUT_COL_BITS-1:0] col;
      logic [svf_pkg::WORD_BITS-1:0]    pixel;
      logic                             last;
   } pixel_write_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [svf_pkg::WORD_BITS-1:0] req_tdata = '0;    // pixel_in
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [svf_pkg::RSP_BITS-1:0]  rsp_tdata;         // out_row, out_col, out_pixel
   logic                          rsp_tlast;         // last_of_run
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [svf_pkg::ADDR_BITS-1:0] csr_paddr = '0;
   logic [svf_pkg::CSR_BITS-1:0]  csr_pwdata = '0;
   logic [svf_pkg::CSR_BITS-1:0]  csr_prdata;
   logic                          csr_pready;

   // shadow of the register file
   logic [svf_pkg::MODE_BITS-1:0]  mode_reg = svf_pkg::MODE_PASS;
   logic                           blur_reg = 1'b0;
   logic [svf_pkg::DIM_BITS-1:0]   width_reg = 11'd640;
   logic [svf_pkg::DIM_BITS-1:0]   height_reg = 11'd480;
   logic [svf_pkg::SHIFT_BITS-1:0] red_reg = 5'd16;
   logic [svf_pkg::SHIFT_BITS-1:0] green_reg = 5'd8;
   logic [svf_pkg::SHIFT_BITS-1:0] blue_reg = 5'd0;
   logic [svf_pkg::WORD_BITS-1:0]  alpha_reg = 32'hFF00_0000;

   // filter state
   logic [svf_pkg::WORD_BITS-1:0] line_above [svf_pkg::MAX_WIDTH];
   logic [svf_pkg::WORD_BITS-1:0] held_px = '0;
   logic                          held_on = 1'b0;
   int unsigned                   held_r = 0;
   int unsigned                   held_c = 0;
   int unsigned                   row_cnt = 0;
   int unsigned                   col_cnt = 0;

   pixel_write_type               step_writes [svf_pkg::NSLOT];
   int                            step_count;
   pixel_write_type               writes_due [$];
   logic [svf_pkg::WORD_BITS-1:0] pixels_pending [$];

   logic        quiet = 1'b0;
   int          error_count = 0;
   int unsigned cycles = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          writes_seen = 0;
   int          items_sent = 0;

   scanline_video_filter_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned fit_dim(int unsigned v, int unsigned top);
      if (v < 2) return 2;
      if (v > top) return top;
      return v;
   endfunction

   function automatic logic [svf_pkg::WORD_BITS-1:0] lane_mask();
      logic [svf_pkg::WORD_BITS-1:0] lsbs;
      lsbs = '0;
      lsbs[red_reg] = 1'b1;
      lsbs[green_reg] = 1'b1;
      lsbs[blue_reg] = 1'b1;
      return ~(lsbs | alpha_reg);
   endfunction

   // channel-safe average: low channel bits and alpha cleared before the add
   function automatic logic [svf_pkg::WORD_BITS-1:0] pair_mean(
      logic [svf_pkg::WORD_BITS-1:0] a, logic [svf_pkg::WORD_BITS-1:0] b);
      logic [svf_pkg::WORD_BITS-1:0] m;
      logic [svf_pkg::WORD_BITS:0]   total;
      m = lane_mask();
      total = {1'b0, a & m} + {1'b0, b & m};
      return total[svf_pkg::WORD_BITS:1];
   endfunction

   function automatic void record_write(int unsigned r, int unsigned c,
                                        logic [svf_pkg::WORD_BITS-1:0] p);
      if (step_count < svf_pkg::NSLOT) begin
         step_writes[step_count] = {svf_pkg::OUT_ROW_BITS'(r), svf_pkg::OUT_COL_BITS'(c),
                                    p, 1'b0};
         step_count++;
      end
   endfunction

   function automatic void write_even(int unsigned r, int unsigned c,
                                      logic [svf_pkg::WORD_BITS-1:0] f, int unsigned h);
      record_write(r, c, f);
      if (mode_reg == svf_pkg::MODE_MIX && r >= 1 && r + 1 < h)
         record_write(r - 1, c, pair_mean(line_above[c], f));
      line_above[c] = f;
   endfunction

   task automatic filter_pixel(logic [svf_pkg::WORD_BITS-1:0] p);
      int unsigned w, h, r, c;
      int k;
      w = fit_dim(32'(width_reg), svf_pkg::MAX_WIDTH);
      h = fit_dim(32'(height_reg), svf_pkg::MAX_HEIGHT);
      r = row_cnt;
      c = col_cnt;
      step_count = 0;
      if (held_on && held_r != r) begin
         write_even(held_r, held_c, held_px, h);
         held_on = 1'b0;
      end
      if (r % 2 == 0) begin
         if (held_on) begin
            write_even(r, held_c, pair_mean(held_px, p), h);
            held_on = 1'b0;
         end
         if (blur_reg && c % 2 == 1 && c + 1 < w) begin
            held_px = p;
            held_r = r;
            held_c = c;
            held_on = 1'b1;
         end else begin
            write_even(r, c, p, h);
         end
      end else begin
         case (mode_reg)
            svf_pkg::MODE_MIX: begin
               if (r + 2 >= h) record_write(r, c, '0);
            end
            svf_pkg::MODE_HALF: begin
               if (r + 2 >= h) record_write(r, c, '0);
               else record_write(r, c, (line_above[c] & lane_mask()) >> 1);
            end
            svf_pkg::MODE_COPY: record_write(r, c, line_above[c]);
            svf_pkg::MODE_ZERO: record_write(r, c, '0);
            default: record_write(r, c, p);
         endcase
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
      for (k = 0; k < step_count; k++) begin
         if (k == step_count - 1) step_writes[k].last = 1'b1;
         writes_due.push_back(step_writes[k]);
      end
   endtask

   task automatic check_write();
      pixel_write_type want, got;
      got.row = rsp_tdata[0 +: svf_pkg::OUT_ROW_BITS];
      got.col = rsp_tdata[svf_pkg::OUT_ROW_BITS +: svf_pkg::OUT_COL_BITS];
      got.pixel = rsp_tdata[svf_pkg::OUT_ROW_BITS + svf_pkg::OUT_COL_BITS +: svf_pkg::WORD_BITS];
      got.last = rsp_tlast;
      if (writes_due.size() == 0) begin
         error_count++;
         $display("%0t: unexpected write, expected none", $time);
         $display("%0t:   actual row %0d col %0d pixel %08h last %0b",
                  $time, got.row, got.col, got.pixel, got.last);
      end else begin
         want = writes_due.pop_front();
         if (want !== got) begin
            error_count++;
            $display("%0t: write mismatch, expected row %0d col %0d pixel %08h last %0b",
                     $time, want.row, want.col, want.pixel, want.last);
            $display("%0t:                 actual   row %0d col %0d pixel %08h last %0b",
                     $time, got.row, got.col, got.pixel, got.last);
         end
      end
   endtask

   // pixel source
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) filter_pixel(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(0, 11);
               req_tvalid <= 1'b0;
            end else if (pixels_pending.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pixels_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // write sink and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            writes_seen++;
            check_write();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (writes_seen >= HOLD_AFTER && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(svf_pkg::reg_index_type idx,
                            logic [svf_pkg::CSR_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         svf_pkg::REG_SCAN_MODE:    mode_reg = value[svf_pkg::MODE_BITS-1:0];
         svf_pkg::REG_BLUR_ON:      blur_reg = value[0];
         svf_pkg::REG_LINE_WIDTH:   width_reg = value[svf_pkg::DIM_BITS-1:0];
         svf_pkg::REG_FRAME_HEIGHT: height_reg = value[svf_pkg::DIM_BITS-1:0];
         svf_pkg::REG_RED_SHIFT:    red_reg = value[svf_pkg::SHIFT_BITS-1:0];
         svf_pkg::REG_GREEN_SHIFT:  green_reg = value[svf_pkg::SHIFT_BITS-1:0];
         svf_pkg::REG_BLUE_SHIFT:   blue_reg = value[svf_pkg::SHIFT_BITS-1:0];
         default:                   alpha_reg = value;
      endcase
      @(negedge clock);
   endtask

   task automatic set_all(logic [svf_pkg::MODE_BITS-1:0] m, logic b,
                          logic [svf_pkg::DIM_BITS-1:0] w,
                          logic [svf_pkg::DIM_BITS-1:0] h,
                          logic [svf_pkg::SHIFT_BITS-1:0] rs,
                          logic [svf_pkg::SHIFT_BITS-1:0] gs,
                          logic [svf_pkg::SHIFT_BITS-1:0] bs,
                          logic [svf_pkg::WORD_BITS-1:0] a);
      write_reg(svf_pkg::REG_SCAN_MODE, svf_pkg::CSR_BITS'(m));
      write_reg(svf_pkg::REG_BLUR_ON, svf_pkg::CSR_BITS'(b));
      write_reg(svf_pkg::REG_LINE_WIDTH, svf_pkg::CSR_BITS'(w));
      write_reg(svf_pkg::REG_FRAME_HEIGHT, svf_pkg::CSR_BITS'(h));
      write_reg(svf_pkg::REG_RED_SHIFT, svf_pkg::CSR_BITS'(rs));
      write_reg(svf_pkg::REG_GREEN_SHIFT, svf_pkg::CSR_BITS'(gs));
      write_reg(svf_pkg::REG_BLUE_SHIFT, svf_pkg::CSR_BITS'(bs));
      write_reg(svf_pkg::REG_ALPHA_BITS, a);
   endtask

   // stream idle, every write in, pipeline given time to settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_pending.size() != 0 || req_tvalid || writes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [svf_pkg::WORD_BITS-1:0] any_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_pixel(logic [svf_pkg::WORD_BITS-1:0] p);
      pixels_pending.push_back(p);
      items_sent++;
   endtask

   task automatic send_frames(int unsigned count);
      int unsigned n, k;
      n = count * fit_dim(32'(width_reg), svf_pkg::MAX_WIDTH) *
          fit_dim(32'(height_reg), svf_pkg::MAX_HEIGHT);
      for (k = 0; k < n; k++) queue_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic finish_frame();
      wait_idle();
      while (row_cnt != 0 || col_cnt != 0) begin
         queue_pixel(any_pixel());
         wait_idle();
      end
   endtask

   initial begin
      int i;
      int phase;
      logic [svf_pkg::MODE_BITS-1:0] m;
      logic [svf_pkg::DIM_BITS-1:0] w, h;
      logic [svf_pkg::SHIFT_BITS-1:0] rs, gs, bs;
      logic [svf_pkg::WORD_BITS-1:0] a;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extreme pixels and shifts, plain pass
      set_all(svf_pkg::MODE_PASS, 1'b0, 11'd2, 11'd2, 5'd31, 5'd0, 5'd31, 32'h0);
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h8000_0001);
      queue_pixel(32'h7FFF_FFFE);
      wait_idle();

      // mix with blur: delayed odd rows, zeroed last odd row, up to four writes per word
      set_all(svf_pkg::MODE_MIX, 1'b1, 11'd4, 11'd4, 5'd16, 5'd8, 5'd0, 32'hFF00_0000);
      for (i = 0; i < 16; i++)
         queue_pixel((i % 4 == 0) ? '1 : (i % 4 == 2) ? '0 : $urandom);
      wait_idle();

      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
         if (phase == 3) begin
            // widest line and tallest frame, then shrink mid-frame in pass mode
            set_all(svf_pkg::MODE_PASS, 1'b1, 11'd2047, 11'd2047,
                    svf_pkg::SHIFT_BITS'($urandom), svf_pkg::SHIFT_BITS'($urandom),
                    svf_pkg::SHIFT_BITS'($urandom), $urandom);
            for (i = 0; i < WIDE_RUN; i++) queue_pixel(any_pixel());
            wait_idle();
            write_reg(svf_pkg::REG_LINE_WIDTH, 32'd0);
            write_reg(svf_pkg::REG_FRAME_HEIGHT, 32'd1);
            write_reg(svf_pkg::REG_BLUR_ON, 32'd0);
            finish_frame();
         end else begin
            m = svf_pkg::MODE_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                                                                  $urandom_range(0, 4));
            w = svf_pkg::DIM_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
                                                                 $urandom_range(2, 9));
            h = svf_pkg::DIM_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
                                                                 $urandom_range(2, 7));
            if ($urandom_range(0, 3) == 0) begin
               rs = 5'd16;
               gs = 5'd8;
               bs = 5'd0;
            end else begin
               rs = svf_pkg::SHIFT_BITS'($urandom);
               gs = svf_pkg::SHIFT_BITS'($urandom);
               bs = svf_pkg::SHIFT_BITS'($urandom);
            end
            case ($urandom_range(0, 3))
               0: a = '0;
               1: a = '1;
               2: a = 32'hFF00_0000;
               default: a = $urandom;
            endcase
            set_all(m, 1'($urandom_range(0, 1)), w, h, rs, gs, bs, a);
            send_frames($urandom_range(1, 2));
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/svf_pkg.sv
rtl/svf_ram.sv
rtl/svf_pipe.sv
rtl/svf_outbuf.sv
rtl/scanline_video_filter_top.sv
verif/scanline_video_filter_top_tb.sv
